>>> rtl/sml_pkg.sv
package sml_pkg;

  // line store geometry
  localparam int ACC_DEPTH = 4096;
  localparam int ACC_AW    = 12;
  localparam int ACC_W     = 40;

  // register limits
  localparam int MAX_LOOKS   = 16;
  localparam int MAX_COLUMNS = 4096;

  // register indexes
  localparam logic [2:0] REG_AZ_LOOKS = 3'd0;
  localparam logic [2:0] REG_RG_LOOKS = 3'd1;
  localparam logic [2:0] REG_MODE     = 3'd2;
  localparam logic [2:0] REG_COLS     = 3'd3;
  localparam logic [2:0] REG_ROWS     = 3'd4;

  // iterative unit lengths
  localparam int SQ_IN_W  = 56;
  localparam int SQ_OUT_W = 28;
  localparam int DV_W     = 56;

  typedef struct packed {
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel;
    logic        frame_last;
    logic        status;
  } out_t;

  typedef struct packed {
    logic [4:0]  row_looks;
    logic [4:0]  col_looks;
    logic        average_mode;
    logic [12:0] image_columns;
    logic [15:0] image_rows;
    logic [8:0]  count;
    logic        bad;
  } cfg_t;

  typedef struct packed {
    logic              load_in;
    logic [ACC_AW-1:0] addr;
    logic              mem_rd;
    logic              sq_load;
    logic              sq_src;
    logic              sq_step;
    logic              acc;
    logic              acc_first;
    logic              acc_emit;
    logic              dv_load;
    logic              dv_step;
    logic              out_load;
    logic              out_err;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic sq_last;
    logic dv_last;
  } sts_t;

endpackage

>>> rtl/sml_regs.sv
module sml_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sml_pkg::cfg_t     cfg,
  output logic              restart
);
  import sml_pkg::*;

  logic [4:0]  az_r, az_nxt;
  logic [4:0]  rg_r, rg_nxt;
  logic        mode_r, mode_nxt;
  logic [12:0] cols_r, cols_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_comb begin
    az_nxt   = az_r;
    rg_nxt   = rg_r;
    mode_nxt = mode_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    restart  = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_AZ_LOOKS: begin az_nxt = pwdata[4:0]; restart = 1'b1; end
        REG_RG_LOOKS: begin rg_nxt = pwdata[4:0]; restart = 1'b1; end
        REG_MODE:     begin mode_nxt = pwdata[0]; restart = 1'b1; end
        REG_COLS:     begin cols_nxt = pwdata[12:0]; restart = 1'b1; end
        REG_ROWS:     begin rows_nxt = pwdata[15:0]; restart = 1'b1; end
        default:      restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_r   <= 5'd1;
      rg_r   <= 5'd1;
      mode_r <= 1'b0;
      cols_r <= 13'(MAX_COLUMNS);
      rows_r <= 16'hFFFF;
    end else begin
      az_r   <= az_nxt;
      rg_r   <= rg_nxt;
      mode_r <= mode_nxt;
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
    end
  end

  // readback
  always_comb begin
    unique case (idx)
      REG_AZ_LOOKS: prdata = {27'd0, az_r};
      REG_RG_LOOKS: prdata = {27'd0, rg_r};
      REG_MODE:     prdata = {31'd0, mode_r};
      REG_COLS:     prdata = {19'd0, cols_r};
      REG_ROWS:     prdata = {16'd0, rows_r};
      default:      prdata = 32'd0;
    endcase
  end

  // derived values
  always_comb begin
    cfg.row_looks     = az_r;
    cfg.col_looks     = rg_r;
    cfg.average_mode  = mode_r;
    cfg.image_columns = cols_r;
    cfg.image_rows    = rows_r;
    cfg.count         = 9'(10'(az_r) * 10'(rg_r));
    cfg.bad = (az_r == 5'd0) || (az_r > 5'(MAX_LOOKS)) ||
              (rg_r == 5'd0) || (rg_r > 5'(MAX_LOOKS)) ||
              (cols_r == 13'd0) || (cols_r > 13'(MAX_COLUMNS)) ||
              (rows_r == 16'd0) ||
              (16'(az_r) > rows_r) || (13'(rg_r) > cols_r);
  end

endmodule

>>> rtl/sml_datapath.sv
module sml_datapath (
  input  logic          clk,
  input  sml_pkg::cfg_t cfg,
  input  sml_pkg::cmd_t cmd,
  input  sml_pkg::in_t  in_data,
  output sml_pkg::sts_t sts,
  output sml_pkg::out_t out_data
);
  import sml_pkg::*;

  logic [16:0]         re_r, im_r;
  logic [ACC_AW-1:0]   addr_r;
  logic [31:0]         p_r;
  logic [ACC_W-1:0]    mem [ACC_DEPTH];
  logic [ACC_W-1:0]    rd_r;
  logic [ACC_W-1:0]    sum_r;
  logic [ACC_W-1:0]    sum_nxt;
  logic [ACC_W-1:0]    addend;

  logic [SQ_IN_W-1:0]  sq_x_r;
  logic [29:0]         sq_rem_r;
  logic [SQ_OUT_W-1:0] sq_root_r;
  logic [4:0]          sq_cnt_r;
  logic [31:0]         sq_rem2;
  logic [31:0]         sq_trial;

  logic [DV_W-1:0]     dv_r;
  logic [7:0]          dv_rem_r;
  logic [5:0]          dv_cnt_r;
  logic [8:0]          dv_rem2;
  logic                dv_ge;

  out_t                out_r;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 17'(-18'(v)) : 17'(v);
  endfunction

  // sample capture and power
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      re_r   <= abs16(in_data.sample_real);
      im_r   <= abs16(in_data.sample_imag);
      addr_r <= cmd.addr;
    end
    if (cmd.mem_rd) begin
      p_r  <= 32'(34'(re_r) * 34'(re_r) + 34'(im_r) * 34'(im_r));
      rd_r <= mem[addr_r];
    end
  end

  // column accumulate
  assign addend  = cfg.average_mode ? ACC_W'(p_r) : ACC_W'(sq_root_r);
  assign sum_nxt = (cmd.acc_first ? '0 : rd_r) + addend;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      mem[addr_r] <= cmd.acc_emit ? '0 : sum_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // square root, two input bits per step
  assign sq_rem2  = {sq_rem_r, sq_x_r[SQ_IN_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_x_r    <= cmd.sq_src ? dv_r : {8'd0, p_r, 16'd0};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= '0;
    end else if (cmd.sq_step) begin
      sq_x_r   <= {sq_x_r[SQ_IN_W-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (sq_rem2 >= sq_trial) begin
        sq_rem_r  <= 30'(sq_rem2 - sq_trial);
        sq_root_r <= {sq_root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_rem2[29:0];
        sq_root_r <= {sq_root_r[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.sq_last = (sq_cnt_r == 5'(SQ_OUT_W - 1));

  // restoring divide by block size, one quotient bit per step
  assign dv_rem2 = {dv_rem_r, dv_r[DV_W-1]};
  assign dv_ge   = (dv_rem2 >= cfg.count);

  always_ff @(posedge clk) begin
    if (cmd.dv_load) begin
      dv_r     <= cfg.average_mode ? {sum_r, 16'd0} : DV_W'(sum_r);
      dv_rem_r <= '0;
      dv_cnt_r <= '0;
    end else if (cmd.dv_step) begin
      dv_r     <= {dv_r[DV_W-2:0], dv_ge};
      dv_rem_r <= dv_ge ? 8'(dv_rem2 - cfg.count) : dv_rem2[7:0];
      dv_cnt_r <= dv_cnt_r + 6'd1;
    end
  end

  assign sts.dv_last = (dv_cnt_r == 6'(DV_W - 1));

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_r.pixel      <= '0;
        out_r.frame_last <= 1'b0;
        out_r.status     <= 1'b1;
      end else begin
        out_r.pixel      <= cfg.average_mode ? sq_root_r[23:0] : dv_r[23:0];
        out_r.frame_last <= cmd.out_last;
        out_r.status     <= 1'b0;
      end
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/sml_ctrl.sv
module sml_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  sml_pkg::cfg_t cfg,
  input  logic          restart,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sml_pkg::sts_t sts,
  output sml_pkg::cmd_t cmd
);
  import sml_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SQA0 = 4'd2;
  localparam logic [3:0] S_SQA  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_DIV0 = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SQP0 = 4'd7;
  localparam logic [3:0] S_SQP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        first_r, first_nxt;
  logic        emit_r, emit_nxt;
  logic        last_r, last_nxt;
  logic        err_r, err_nxt;

  logic [15:0] row_pos_r, row_pos_nxt;
  logic [11:0] col_pos_r, col_pos_nxt;
  logic [3:0]  rib_r, rib_nxt;
  logic [3:0]  cib_r, cib_nxt;
  logic [11:0] ocol_r, ocol_nxt;
  logic [16:0] row_base_r, row_base_nxt;
  logic [12:0] col_base_r, col_base_nxt;

  logic        accept;
  logic        in_used;
  logic        emit_now;
  logic        last_now;
  logic [4:0]  cib_inc;
  logic [4:0]  rib_inc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);

  // block geometry of the current sample
  assign in_used  = (18'(row_base_r) + 18'(cfg.row_looks) <= 18'(cfg.image_rows)) &&
                    (14'(col_base_r) + 14'(cfg.col_looks) <= 14'(cfg.image_columns));
  assign cib_inc  = 5'(cib_r) + 5'd1;
  assign rib_inc  = 5'(rib_r) + 5'd1;
  assign emit_now = (rib_inc == cfg.row_looks) && (cib_inc == cfg.col_looks);
  assign last_now = emit_now &&
    (18'(row_base_r) + 18'({cfg.row_looks, 1'b0}) > 18'(cfg.image_rows)) &&
    (14'(col_base_r) + 14'({cfg.col_looks, 1'b0}) > 14'(cfg.image_columns));

  // raster position advance
  always_comb begin
    row_pos_nxt  = row_pos_r;
    col_pos_nxt  = col_pos_r;
    rib_nxt      = rib_r;
    cib_nxt      = cib_r;
    ocol_nxt     = ocol_r;
    row_base_nxt = row_base_r;
    col_base_nxt = col_base_r;
    if (restart) begin
      row_pos_nxt  = '0;
      col_pos_nxt  = '0;
      rib_nxt      = '0;
      cib_nxt      = '0;
      ocol_nxt     = '0;
      row_base_nxt = '0;
      col_base_nxt = '0;
    end else if (accept && !cfg.bad) begin
      if (cib_inc >= cfg.col_looks) begin
        cib_nxt      = '0;
        ocol_nxt     = ocol_r + 12'd1;
        col_base_nxt = col_base_r + 13'(cfg.col_looks);
      end else begin
        cib_nxt = cib_inc[3:0];
      end
      col_pos_nxt = col_pos_r + 12'd1;
      if (13'(col_pos_r) + 13'd1 >= cfg.image_columns) begin
        col_pos_nxt  = '0;
        cib_nxt      = '0;
        ocol_nxt     = '0;
        col_base_nxt = '0;
        if (rib_inc >= cfg.row_looks) begin
          rib_nxt      = '0;
          row_base_nxt = row_base_r + 17'(cfg.row_looks);
        end else begin
          rib_nxt = rib_inc[3:0];
        end
        row_pos_nxt = row_pos_r + 16'd1;
        if (17'(row_pos_r) + 17'd1 >= 17'(cfg.image_rows)) begin
          row_pos_nxt  = '0;
          rib_nxt      = '0;
          row_base_nxt = '0;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    emit_nxt      = emit_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    cmd           = '0;
    cmd.addr      = ocol_r;
    cmd.sq_src    = 1'b0;
    cmd.acc_first = first_r;
    cmd.acc_emit  = emit_r;
    cmd.out_err   = err_r;
    cmd.out_last  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cfg.bad) begin
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (in_used) begin
            cmd.load_in = 1'b1;
            err_nxt     = 1'b0;
            first_nxt   = (rib_r == 4'd0) && (cib_r == 4'd0);
            emit_nxt    = emit_now;
            last_nxt    = last_now;
            state_nxt   = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = cfg.average_mode ? S_ACC : S_SQA0;
      end
      S_SQA0: begin
        cmd.sq_load = 1'b1;
        state_nxt   = S_SQA;
      end
      S_SQA: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = emit_r ? S_DIV0 : S_IDLE;
      end
      S_DIV0: begin
        cmd.dv_load = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.dv_step = 1'b1;
        if (sts.dv_last) state_nxt = cfg.average_mode ? S_SQP0 : S_OUT;
      end
      S_SQP0: begin
        cmd.sq_load = 1'b1;
        cmd.sq_src  = 1'b1;
        state_nxt   = S_SQP;
      end
      S_SQP: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result transfer flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      rib_r       <= '0;
      cib_r       <= '0;
      ocol_r      <= '0;
      row_base_r  <= '0;
      col_base_r  <= '0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      rib_r       <= rib_nxt;
      cib_r       <= cib_nxt;
      ocol_r      <= ocol_nxt;
      row_base_r  <= row_base_nxt;
      col_base_r  <= col_base_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    emit_r  <= emit_nxt;
    last_r  <= last_nxt;
  end

endmodule

>>> rtl/sar_multilook_block_average.sv
// one sample at a time: edge samples outside full blocks are dropped as taken,
// a config-error sample goes straight to the output register; accumulate runs
// the 28-step square root in amplitude mode only; a block corner adds the
// 56-step divider, and in power mode the 28-step square root after it
// a finished pixel waits in the output register while the next sample is taken
// synchronous active-low reset restores the default registers and frame start
module sar_multilook_block_average (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sml_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sml_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import sml_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic restart;

  // configuration registers
  sml_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // sequencer
  sml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and line store
  sml_datapath u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sml_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 250;

  // one directed row: a sample and, where obvious, its typed result
  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    bit                 typed;
    out_t               pix;
  } dir_row_t;

  // typed result that travels with each sent sample
  typedef struct {
    bit   typed;
    out_t pix;
  } tag_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block's registers and frame state
  logic [4:0]      az_looks;
  logic [4:0]      rg_looks;
  logic            avg_mode;
  logic [12:0]     n_cols;
  logic [15:0]     n_rows;
  logic [63:0]     col_sums [ACC_DEPTH];
  int unsigned     row_pos, col_pos, row_in_blk, col_in_blk, blk_col;

  out_t            pixels_due [$];
  tag_t            tags [$];
  int              errors;
  int              quiet_cycles;
  bit              src_idle_on;
  bit              snk_idle_on;

  sar_multilook_block_average i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag16(logic [15:0] v);
    return v[15] ? 64'h10000 - {48'd0, v} : {48'd0, v};
  endfunction

  function automatic void restart_frame();
    foreach (col_sums[i]) col_sums[i] = 0;
    row_pos = 0; col_pos = 0; row_in_blk = 0; col_in_blk = 0; blk_col = 0;
  endfunction

  function automatic void shadow_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_AZ_LOOKS: az_looks = v[4:0];
      REG_RG_LOOKS: rg_looks = v[4:0];
      REG_MODE:     avg_mode = v[0];
      REG_COLS:     n_cols   = v[12:0];
      REG_ROWS:     n_rows   = v[15:0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic bit looks_bad();
    if (az_looks == 0 || az_looks > MAX_LOOKS) return 1;
    if (rg_looks == 0 || rg_looks > MAX_LOOKS) return 1;
    if (n_cols == 0 || n_cols > MAX_COLUMNS) return 1;
    if (n_rows == 0) return 1;
    return (az_looks > n_rows) || (rg_looks > n_cols);
  endfunction

  // advance the frame by one sample, returns 1 when a pixel is due
  function automatic bit average_sample(in_t d, output out_t px);
    int unsigned used_rows, used_cols;
    logic [63:0] pw, add, cnt, sum;
    bit          hit;
    hit = 0;
    px = '0;
    if (looks_bad()) begin
      px.status = 1'b1;
      return 1;
    end
    used_rows = (n_rows / az_looks) * az_looks;
    used_cols = (n_cols / rg_looks) * rg_looks;
    if (row_pos < used_rows && col_pos < used_cols) begin
      pw = mag16(d.sample_real) * mag16(d.sample_real)
         + mag16(d.sample_imag) * mag16(d.sample_imag);
      add = avg_mode ? pw : int_sqrt(pw << 16);
      col_sums[blk_col % ACC_DEPTH] += add;
      if (row_in_blk + 1 == az_looks && col_in_blk + 1 == rg_looks) begin
        cnt = az_looks * rg_looks;
        sum = col_sums[blk_col % ACC_DEPTH];
        sum = avg_mode ? int_sqrt((sum << 16) / cnt) : sum / cnt;
        px.pixel = sum[23:0];
        px.frame_last = (row_pos + 1 == used_rows && col_pos + 1 == used_cols);
        col_sums[blk_col % ACC_DEPTH] = 0;
        hit = 1;
      end
    end
    col_in_blk++;
    if (col_in_blk >= rg_looks) begin
      col_in_blk = 0;
      blk_col++;
    end
    col_pos++;
    if (col_pos >= n_cols) begin
      col_pos = 0; col_in_blk = 0; blk_col = 0;
      row_in_blk++;
      if (row_in_blk >= az_looks) row_in_blk = 0;
      row_pos++;
      if (row_pos >= n_rows) begin
        row_pos = 0; row_in_blk = 0;
      end
    end
    return hit;
  endfunction

  // transfers on both channels, predictor and checker
  always @(posedge clk) begin
    out_t px;
    out_t want;
    tag_t tag;
    bit   busy;
    busy = 1'b0;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (psel && penable && pwrite && pready) busy = 1'b1;
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        tag = tags.pop_front();
        if (average_sample(in_data, px))
          pixels_due.push_back(tag.typed ? tag.pix : px);
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, out_data);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (out_data.pixel !== want.pixel || out_data.frame_last !== want.frame_last
              || out_data.status !== want.status) begin
            $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                     want.pixel, want.frame_last, want.status,
                     out_data.pixel, out_data.frame_last, out_data.status);
            errors++;
          end
        end
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side stalls at random while snk_idle_on is set
  always @(posedge clk) begin
    out_stall <= snk_idle_on && ($urandom_range(99) < 37);
  end

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im,
                             bit typed = 1'b0, out_t pix = '0);
    tags.push_back('{typed, pix});
    while (src_idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample_real <= re;
    in_data.sample_imag <= im;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_reg(idx, v);
  endtask

  task automatic set_geometry(int az, int rg, int md, int c, int r);
    write_reg(REG_AZ_LOOKS, az);
    write_reg(REG_RG_LOOKS, rg);
    write_reg(REG_MODE, md);
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
  endtask

  function automatic logic [15:0] rand_part();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_sample(rand_part(), rand_part());
  endtask

  dir_row_t dir_rows [$];
  out_t     err_px;
  int       sent;
  int       az, rg, c, r, n;

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    src_idle_on = 1; snk_idle_on = 1;
    az_looks = 1; rg_looks = 1; avg_mode = 0; n_cols = 4096; n_rows = 65535;
    restart_frame();
    err_px = '0;
    err_px.status = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows on the reset geometry: one pixel per sample
    dir_rows.push_back('{16'sd0, 16'sd0, 1, '{24'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{-16'sd32768, -16'sd32768, 1, '{24'd11863283, 1'b0, 1'b0}});
    dir_rows.push_back('{16'sd32767, 16'sd0, 1, '{24'd8388352, 1'b0, 1'b0}});
    dir_rows.push_back('{-16'sd32768, 16'sd0, 1, '{24'd8388608, 1'b0, 1'b0}});
    dir_rows.push_back('{16'sd0, -16'sd32768, 1, '{24'd8388608, 1'b0, 1'b0}});
    dir_rows.push_back('{16'sd3, 16'sd4, 1, '{24'd1280, 1'b0, 1'b0}});
    dir_rows.push_back('{-16'sd1, 16'sd1, 0, '0});
    dir_rows.push_back('{16'sd32767, 16'sd32767, 0, '0});
    dir_rows.push_back('{16'sh5555, -16'sh5556, 0, '0});
    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].re, dir_rows[i].im, dir_rows[i].typed, dir_rows[i].pix);
    end
    in_valid <= 1'b0;

    // looks or image size out of range, or looks larger than the image: every sample flags status
    write_reg(REG_AZ_LOOKS, 0);  send_sample(16'sd1, 16'sd2, 1'b1, err_px);
    write_reg(REG_AZ_LOOKS, 20); send_sample(16'sd1, 16'sd2, 1'b1, err_px);
    write_reg(REG_AZ_LOOKS, 1);
    write_reg(REG_COLS, 5000);   send_sample(16'sd1, 16'sd2, 1'b1, err_px);
    write_reg(REG_COLS, 0);      send_sample(16'sd1, 16'sd2, 1'b1, err_px);
    write_reg(REG_COLS, 8);
    write_reg(REG_ROWS, 0);      send_sample(16'sd1, 16'sd2, 1'b1, err_px);
    set_geometry(3, 1, 0, 8, 2); send_sample(16'sd1, 16'sd2, 1'b1, err_px);

    // largest block in power mode, wide amplitude blocks with an edge column,
    // the widest line and a one-sample frame
    set_geometry(16, 16, 1, 16, 16); send_random(256);
    set_geometry(2, 16, 0, 17, 2);   send_random(34);
    set_geometry(1, 16, 0, 4096, 1); send_random(48);
    set_geometry(1, 1, 1, 1, 1);     send_random(3);

    // random geometries with a few broken ones, each run capped at 40 samples
    sent = 0;
    while (sent < 150) begin
      c = $urandom_range(1, 24);
      r = $urandom_range(1, 12);
      az = $urandom_range(1, (r < 16) ? r : 16);
      rg = $urandom_range(1, (c < 16) ? c : 16);
      if ($urandom_range(9) == 0) az = r + 1;
      set_geometry(az, rg, $urandom_range(1), c, r);
      n = c * r * $urandom_range(1, 2);
      if ($urandom_range(4) == 0) n = $urandom_range(1, n);
      if (n > 40) n = 40;
      for (int k = 0; k < n; k++) begin
        src_idle_on = !(sent >= 30 && sent < 100);
        snk_idle_on = src_idle_on;
        // hold off mid-frame until the pipe is empty
        if (sent == 110) begin
          in_valid <= 1'b0;
          while (pixels_due.size() != 0) @(posedge clk);
        end
        send_sample(rand_part(), rand_part());
        sent++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
